[design/ritc_pkg.sv]
// Package for the Rayleigh inverse-transform core: constants, cell payload types.
// No dependencies; the cell modules and the top level import it.
package ritc_pkg;

    localparam int unsigned NUM_STEPS = 32;

    localparam logic [31:0] LN2X2_Q31  = 32'hB172_17F8;
    localparam logic [31:0] QMAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] SCALE_RST  = 32'h0001_0000;
    localparam logic [31:0] OFFSET_RST = 32'h0000_0000;

    // Register indexes (byte address / 4)
    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    typedef struct packed {
        logic [31:0] x;     // mantissa, Q1.31 in [1,2)
        logic [31:0] frac;  // log2 fraction bits gathered so far
        logic [5:0]  e;     // integer part of log2
        logic        zero;  // tail probability of zero
    } t_log_data;

    typedef struct packed {
        logic [63:0] n;     // remainder
        logic [63:0] res;   // partial root
        logic        zero;
    } t_sqrt_data;

endpackage

[design/ritc_if.sv]
// Handshake interfaces for the input and result channels.
// Depends on nothing; payload widths follow the field list.
interface ritc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] probability;
    logic        upper_tail;

    modport source (output valid, output probability, output upper_tail, input ready);
    modport sink   (input valid, input probability, input upper_tail, output ready);
endinterface

interface ritc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] quantile;
    logic        saturated;

    modport source (output valid, output quantile, output saturated, input ready);
    modport sink   (input valid, input quantile, input saturated, output ready);
endinterface

[design/ritc_log_cell.sv]
// One squaring step of the log2 fraction extraction.
// Depends on ritc_pkg.
module ritc_log_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ritc_pkg::t_log_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ritc_pkg::t_log_data o_data
);
    import ritc_pkg::*;

    logic [63:0] sq;
    logic [32:0] xs;
    t_log_data   n_data;
    t_log_data   r_data;
    logic        r_valid;

    always_comb begin
        sq          = 64'(i_data.x) * 64'(i_data.x);
        xs          = sq[63:31];
        n_data      = i_data;
        n_data.x    = xs[32] ? xs[32:1] : xs[31:0];
        n_data.frac = {i_data.frac[30:0], xs[32]};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

[design/ritc_sqrt_cell.sv]
// One bit step of the integer square root (two remainder bits per step).
// Depends on ritc_pkg.
module ritc_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_step,
    input  logic                i_valid,
    output logic                o_ready,
    input  ritc_pkg::t_sqrt_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ritc_pkg::t_sqrt_data o_data
);
    import ritc_pkg::*;

    logic [63:0] bitv;
    logic [63:0] trial;
    t_sqrt_data  n_data;
    t_sqrt_data  r_data;
    logic        r_valid;

    always_comb begin
        bitv   = 64'd1 << (7'd62 - {1'b0, i_step, 1'b0});
        trial  = i_data.res + bitv;
        n_data = i_data;
        if (i_data.n >= trial) begin
            n_data.n   = i_data.n - trial;
            n_data.res = (i_data.res >> 1) + bitv;
        end else begin
            n_data.res = i_data.res >> 1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

[design/rayleigh_inverse_transform_core.sv]
// Top level of the Rayleigh inverse-CDF sampler: offset + scale*sqrt(-2 ln q).
// Depends on ritc_pkg, ritc_if, ritc_log_cell and ritc_sqrt_cell.
//
//  channel    | dir | handshake      | payload
//  -----------+-----+----------------+------------------------------------
//  i_sample   | in  | valid/ready    | probability Q0.32, upper_tail
//  o_result   | out | valid/ready    | quantile Q16.16 signed, saturated
//  APB        | in  | psel/penable   | scale (0x0), offset (0x4)
//
// One transaction per clock sustained while o_result accepts. Stages: front end, 32 log
// squaring cells, two multiply/add stages, 32 root cells, scale multiply,
// output register. The two cell chains make up most of the pipeline depth.
// Synchronous active-low reset empties the pipe and loads scale 1.0, offset 0.
// Every stage advances when it is empty or its successor advances, so bubbles
// collapse and input keeps flowing while a result waits at the output.
module rayleigh_inverse_transform_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ritc_in_if.sink     i_sample,
    ritc_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ritc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [31:0] r_scale;
    logic [31:0] r_offset;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_offset <= OFFSET_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SCALE:  r_scale  <= pwdata;
                REG_OFFSET: r_offset <= pwdata;
                default:    r_scale  <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCALE:  prdata = r_scale;
            REG_OFFSET: prdata = r_offset;
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- stage advance chain ----------------
    logic r_vf, r_vp, r_vy, r_vm, r_vo;
    logic adv_f, adv_p, adv_y, adv_m, adv_o;
    logic log_rdy0, sq_rdy0;

    assign adv_o = !r_vo || o_result.ready;
    assign adv_m = !r_vm || adv_o;
    assign adv_y = !r_vy || sq_rdy0;
    assign adv_p = !r_vp || adv_y;
    assign adv_f = !r_vf || log_rdy0;
    assign i_sample.ready = adv_f;

    // ---------------- front end: m, leading one, normalize ----------------
    function automatic logic [5:0] lead_one(input logic [32:0] v);
        logic [5:0] idx;
        idx = 6'd0;
        for (int k = 0; k < 33; k++) begin
            if (v[k]) idx = 6'(k);
        end
        return idx;
    endfunction

    logic [32:0] m;
    logic [5:0]  e;
    logic [32:0] shl;
    t_log_data   n_front, r_front;

    always_comb begin
        m = i_sample.upper_tail ? {1'b0, i_sample.probability}
                                : (33'h1_0000_0000 - {1'b0, i_sample.probability});
        e = lead_one(m);
        // leading one lands at bit 32; dropping bit 0 truncates as a right shift
        shl = m << (6'd32 - e);
        n_front.x    = shl[32:1];
        n_front.frac = 32'd0;
        n_front.e    = e;
        n_front.zero = (m == 33'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (adv_f) begin
            r_vf <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_f && i_sample.valid) begin
            r_front <= n_front;
        end
    end

    // ---------------- log2 cell chain ----------------
    t_log_data          log_d [NUM_STEPS+1];
    logic [NUM_STEPS:0] log_v;
    logic [NUM_STEPS:0] log_r;

    assign log_d[0]  = r_front;
    assign log_v[0]  = r_vf;
    assign log_rdy0  = log_r[0];
    assign log_r[NUM_STEPS] = adv_p;

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_log
        ritc_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (log_v[g]),
            .o_ready (log_r[g]),
            .i_data  (log_d[g]),
            .o_valid (log_v[g+1]),
            .i_ready (log_r[g+1]),
            .o_data  (log_d[g+1])
        );
    end

    // ---------------- T = -log2 q, multiply by 2 ln 2 ----------------
    logic [37:0] t_val;
    logic [37:0] r_pa;
    logic [63:0] r_pb;
    logic        r_zp;

    assign t_val = {6'd32, 32'd0} - {log_d[NUM_STEPS].e, log_d[NUM_STEPS].frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (adv_p) begin
            r_vp <= log_v[NUM_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_p && log_v[NUM_STEPS]) begin
            r_pa <= 38'(t_val[37:32]) * 38'(LN2X2_Q31);
            r_pb <= 64'(t_val[31:0]) * 64'(LN2X2_Q31);
            r_zp <= log_d[NUM_STEPS].zero;
        end
    end

    // ---------------- Y = -2 ln q in Q.48 ----------------
    t_sqrt_data r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vy <= 1'b0;
        end else if (adv_y) begin
            r_vy <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_y && r_vp) begin
            r_y.n    <= {9'd0, r_pa, 17'd0} + {15'd0, r_pb[63:15]};
            r_y.res  <= 64'd0;
            r_y.zero <= r_zp;
        end
    end

    // ---------------- square root cell chain ----------------
    t_sqrt_data         sq_d [NUM_STEPS+1];
    logic [NUM_STEPS:0] sq_v;
    logic [NUM_STEPS:0] sq_r;

    assign sq_d[0] = r_y;
    assign sq_v[0] = r_vy;
    assign sq_rdy0 = sq_r[0];
    assign sq_r[NUM_STEPS] = adv_m;

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_sqrt
        ritc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (5'(g)),
            .i_valid (sq_v[g]),
            .o_ready (sq_r[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .i_ready (sq_r[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // ---------------- scale multiply, round half up ----------------
    logic [63:0] prod;
    logic [64:0] rnd;
    logic [40:0] r_mag;
    logic        r_zm;

    assign prod = 64'(r_scale) * 64'(sq_d[NUM_STEPS].res[31:0]);
    assign rnd  = {1'b0, prod} + 65'h80_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (adv_m) begin
            r_vm <= sq_v[NUM_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_m && sq_v[NUM_STEPS]) begin
            r_mag <= rnd[64:24];
            r_zm  <= sq_d[NUM_STEPS].zero;
        end
    end

    // ---------------- offset add, clamp, output register ----------------
    logic signed [41:0] sum;
    logic               sat;
    logic [31:0]        r_quant;
    logic               r_sat;

    assign sum = $signed({{10{r_offset[31]}}, r_offset}) + $signed({1'b0, r_mag});
    // clamp on a zero tail probability or a sum above the signed range
    assign sat = r_zm || (sum > $signed({10'd0, QMAX}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv_o) begin
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_vm) begin
            r_quant <= sat ? QMAX : sum[31:0];
            r_sat   <= sat;
        end
    end

    assign o_result.valid     = r_vo;
    assign o_result.quantile  = r_quant;
    assign o_result.saturated = r_sat;
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for rayleigh_inverse_transform_core: predicts each quantile
// in fixed point and compares every result transaction. Depends on ritc_pkg, ritc_if and the core.
module testbench;
    import ritc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ritc_in_if  sample_ch ();
    ritc_out_if result_ch ();

    typedef struct packed {
        logic [31:0] probability;
        logic        upper_tail;
    } t_sample;

    typedef struct packed {
        logic [31:0] quantile;
        logic        saturated;
    } t_quantile;

    // Predictor copy of the configuration registers
    logic [31:0] cur_scale = SCALE_RST;
    logic [31:0] cur_offset = OFFSET_RST;

    t_sample   pending_samples[$];
    t_quantile expected_quantiles[$];
    int        mismatch_count = 0;
    logic      hold_sender = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    rayleigh_inverse_transform_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Log2 of m in Q6.32 by repeated squaring of the normalized mantissa
    function automatic logic [63:0] log2_fixed(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] frac;
        int e;
        frac = '0;
        e = 32;
        while (e > 0 && m[e] == 1'b0) e--;
        if (e >= 31) x = m >> (e - 31);
        else x = m << (31 - e);
        for (int i = 0; i < NUM_STEPS; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                x = x >> 1;
            end
        end
        return (64'(e) << 32) + frac;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = '0;
        bitpos = 64'h1 << 62;
        while (bitpos > n) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (n >= root + bitpos) begin
                n = n - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    function automatic t_quantile predict_quantile(input t_sample s);
        t_quantile q;
        logic [63:0] m, t, y, r, mag;
        logic signed [65:0] sum;
        m = s.upper_tail ? {32'h0, s.probability} : (64'h1_0000_0000 - s.probability);
        if (m == 0) begin
            q.quantile = QMAX;
            q.saturated = 1'b1;
            return q;
        end
        t = (64'd32 << 32) - log2_fixed(m);
        y = ((t[63:32] * {32'h0, LN2X2_Q31}) << 17) + ((t[31:0] * {32'h0, LN2X2_Q31}) >> 15);
        r = int_sqrt(y);
        mag = ({32'h0, cur_scale} * r + (64'h1 << 23)) >> 24;
        sum = $signed({{34{cur_offset[31]}}, cur_offset}) + $signed({2'b00, mag});
        if (sum > $signed({34'h0, QMAX})) begin
            q.quantile = QMAX;
            q.saturated = 1'b1;
        end else begin
            q.quantile = sum[31:0];
            q.saturated = 1'b0;
        end
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Driver: present the head of the queue, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            sample_ch.probability <= '0;
            sample_ch.upper_tail <= 1'b0;
        end else if (sample_ch.valid && sample_ch.ready) begin
            expected_quantiles.push_back(predict_quantile(pending_samples.pop_front()));
            send_gap = pick_gap();
            if (send_gap == 0 && !hold_sender && pending_samples.size() > 0) begin
                sample_ch.probability <= pending_samples[0].probability;
                sample_ch.upper_tail <= pending_samples[0].upper_tail;
            end else begin
                sample_ch.valid <= 1'b0;
            end
        end else if (!sample_ch.valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!hold_sender && pending_samples.size() > 0) begin
                sample_ch.valid <= 1'b1;
                sample_ch.probability <= pending_samples[0].probability;
                sample_ch.upper_tail <= pending_samples[0].upper_tail;
            end
        end
    end

    // Monitor: compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_quantile want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_quantiles.size() == 0) begin
                    report_mismatch("unexpected result", result_ch.quantile, '0);
                end else begin
                    want = expected_quantiles.pop_front();
                    if (result_ch.quantile !== want.quantile)
                        report_mismatch("quantile", result_ch.quantile, want.quantile);
                    if (result_ch.saturated !== want.saturated)
                        report_mismatch("saturated", {31'h0, result_ch.saturated},
                                        {31'h0, want.saturated});
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                result_ch.ready <= 1'b0;
            end else begin
                recv_gap = pick_gap();
                result_ch.ready <= (recv_gap == 0);
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(REG_SCALE) << 2) cur_scale = data;
        else if (addr == 3'(REG_OFFSET) << 2) cur_offset = data;
    endtask

    // Block until the sender has drained and every result has come back
    task automatic drain();
        wait (pending_samples.size() == 0 && !sample_ch.valid);
        wait (expected_quantiles.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic [31:0] p, input logic tail);
        pending_samples.push_back('{p, tail});
    endtask

    task automatic queue_random(input int count);
        logic [31:0] p;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0: p = $urandom_range(0, 15);
                1: p = 32'hFFFF_FFFF - $urandom_range(0, 15);
                2: p = 32'h1 << $urandom_range(0, 31);
                default: p = $urandom;
            endcase
            queue_sample(p, 1'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, tails, q equal to one and zero tail probability
        queue_sample(32'h0, 1'b1);
        queue_sample(32'h0, 1'b0);
        queue_sample(32'h1, 1'b1);
        queue_sample(32'h1, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b1);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 1'b1);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h5555_5555, 1'b1);
        queue_sample(32'hAAAA_AAAA, 1'b0);
        queue_sample(32'h0000_FFFF, 1'b1);
        queue_sample(32'hFFFF_0000, 1'b0);
        drain();

        // Largest scale with top offset drives saturation above range
        write_reg(3'(REG_SCALE) << 2, 32'hFFFF_FFFF);
        write_reg(3'(REG_OFFSET) << 2, 32'h7FFF_FFFF);
        queue_sample(32'h1, 1'b1);
        queue_sample(32'h0, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b1);
        queue_random(150);
        drain();

        write_reg(3'(REG_SCALE) << 2, 32'h1);
        write_reg(3'(REG_OFFSET) << 2, 32'h8000_0000);
        queue_sample(32'h1, 1'b1);
        queue_sample(32'h0, 1'b0);
        queue_random(150);

        // Hold the sender until the pipe is empty, then resume
        wait (pending_samples.size() < 75);
        hold_sender = 1'b1;
        wait (!sample_ch.valid && expected_quantiles.size() == 0);
        hold_sender = 1'b0;
        drain();

        // Zero scale lies outside the legal range but must leave only the offset
        write_reg(3'(REG_SCALE) << 2, 32'h0);
        write_reg(3'(REG_OFFSET) << 2, 32'h1234_5678);
        queue_random(60);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(3'(REG_SCALE) << 2, $urandom);
            write_reg(3'(REG_OFFSET) << 2, $urandom);
            queue_random(120);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[filelist.f]
design/ritc_pkg.sv
design/ritc_if.sv
design/ritc_log_cell.sv
design/ritc_sqrt_cell.sv
design/rayleigh_inverse_transform_core.sv
verif/testbench.sv
